/* src/cis_pkg.sv */
package cis_pkg;

  localparam int NUM_CONTACTS = 64;
  localparam int NUM_BODIES   = 64;
  localparam int FRAC_BITS    = 16;
  localparam int CWORDS       = 14;
  localparam int BWORDS       = 5;
  localparam int CDEPTH       = NUM_CONTACTS * CWORDS;
  localparam int BDEPTH       = NUM_BODIES * BWORDS;
  localparam int CA_W         = $clog2(CDEPTH);
  localparam int BA_W         = $clog2(BDEPTH);
  localparam int BI_W         = $clog2(NUM_BODIES);
  localparam int RF_W         = 5;
  localparam int PC_W         = 7;

  localparam int APPLY_PC = 0;
  localparam int WARM_PC  = 42;
  localparam int SOLVE_PC = 56;
  localparam int WORD_PC  = 112;
  localparam int END_PC   = 113;

  typedef enum logic [2:0] {
    OP_WR_C  = 3'd0,
    OP_WR_B  = 3'd1,
    OP_RD_C  = 3'd2,
    OP_RD_B  = 3'd3,
    OP_WARM  = 3'd4,
    OP_SOLVE = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [5:0]         contact_slot;
    logic [5:0]         body_index;
    logic [3:0]         word_select;
    logic signed [31:0] write_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               status;
  } out_t;

  typedef enum logic [3:0] {
    U_LDC, U_LDB, U_STC, U_STB, U_SETB, U_MUL, U_ADD, U_SUB,
    U_NEG, U_MAX0, U_CLAMP, U_XFER, U_JMP, U_END
  } uop_t;

  typedef struct packed {
    uop_t            op;
    logic [RF_W-1:0] d;
    logic [RF_W-1:0] a;
    logic [RF_W-1:0] b;
    logic [3:0]      k;
    logic            bs;
  } uinst_t;

  typedef struct packed {
    logic   accept;
    logic   issue;
    logic   commit;
    uinst_t ui;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE, S_ISSUE, S_COMMIT, S_RESP
  } state_t;

  function automatic uinst_t ui(input uop_t op, input int d, input int a, input int b,
                                input int k, input int bs);
    uinst_t r;
    r.op = op;
    r.d  = RF_W'(d);
    r.a  = RF_W'(a);
    r.b  = RF_W'(b);
    r.k  = 4'(k);
    r.bs = 1'(bs);
    return r;
  endfunction

  function automatic logic [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    else if (v < -64'sd2147483648) return 32'h8000_0000;
    else return v[31:0];
  endfunction

  function automatic uinst_t ucode(input logic [PC_W-1:0] pc);
    uinst_t r;
    case (pc)
      7'd0:   r = ui(U_NEG, 14, 1, 0, 0, 0);
      7'd1:   r = ui(U_MUL, 21, 0, 16, 0, 0);
      7'd2:   r = ui(U_MUL, 26, 14, 17, 0, 0);
      7'd3:   r = ui(U_ADD, 30, 21, 26, 0, 0);
      7'd4:   r = ui(U_MUL, 21, 1, 16, 0, 0);
      7'd5:   r = ui(U_MUL, 26, 0, 17, 0, 0);
      7'd6:   r = ui(U_ADD, 31, 21, 26, 0, 0);
      7'd7:   r = ui(U_LDB, 18, 0, 0, 3, 0);
      7'd8:   r = ui(U_LDB, 19, 0, 0, 4, 0);
      7'd9:   r = ui(U_MUL, 20, 30, 18, 0, 0);
      7'd10:  r = ui(U_MUL, 22, 31, 18, 0, 0);
      7'd11:  r = ui(U_MUL, 21, 5, 31, 0, 0);
      7'd12:  r = ui(U_MUL, 23, 6, 30, 0, 0);
      7'd13:  r = ui(U_SUB, 21, 21, 23, 0, 0);
      7'd14:  r = ui(U_MUL, 23, 21, 19, 0, 0);
      7'd15:  r = ui(U_LDB, 24, 0, 0, 0, 0);
      7'd16:  r = ui(U_SUB, 24, 24, 20, 0, 0);
      7'd17:  r = ui(U_STB, 0, 24, 0, 0, 0);
      7'd18:  r = ui(U_LDB, 24, 0, 0, 1, 0);
      7'd19:  r = ui(U_SUB, 24, 24, 22, 0, 0);
      7'd20:  r = ui(U_STB, 0, 24, 0, 1, 0);
      7'd21:  r = ui(U_LDB, 24, 0, 0, 2, 0);
      7'd22:  r = ui(U_SUB, 24, 24, 23, 0, 0);
      7'd23:  r = ui(U_STB, 0, 24, 0, 2, 0);
      7'd24:  r = ui(U_LDB, 18, 0, 0, 3, 1);
      7'd25:  r = ui(U_LDB, 19, 0, 0, 4, 1);
      7'd26:  r = ui(U_MUL, 20, 30, 18, 0, 0);
      7'd27:  r = ui(U_MUL, 22, 31, 18, 0, 0);
      7'd28:  r = ui(U_MUL, 21, 7, 31, 0, 0);
      7'd29:  r = ui(U_MUL, 23, 8, 30, 0, 0);
      7'd30:  r = ui(U_SUB, 21, 21, 23, 0, 0);
      7'd31:  r = ui(U_MUL, 23, 21, 19, 0, 0);
      7'd32:  r = ui(U_LDB, 24, 0, 0, 0, 1);
      7'd33:  r = ui(U_ADD, 24, 24, 20, 0, 0);
      7'd34:  r = ui(U_STB, 0, 24, 0, 0, 1);
      7'd35:  r = ui(U_LDB, 24, 0, 0, 1, 1);
      7'd36:  r = ui(U_ADD, 24, 24, 22, 0, 0);
      7'd37:  r = ui(U_STB, 0, 24, 0, 1, 1);
      7'd38:  r = ui(U_LDB, 24, 0, 0, 2, 1);
      7'd39:  r = ui(U_ADD, 24, 24, 23, 0, 0);
      7'd40:  r = ui(U_STB, 0, 24, 0, 2, 1);
      7'd41:  r = ui(U_END, 0, 0, 0, 0, 0);
      7'd42:  r = ui(U_LDC, 0, 0, 0, 0, 0);
      7'd43:  r = ui(U_LDC, 1, 0, 0, 1, 0);
      7'd44:  r = ui(U_LDC, 2, 0, 0, 2, 0);
      7'd45:  r = ui(U_LDC, 3, 0, 0, 3, 0);
      7'd46:  r = ui(U_LDC, 4, 0, 0, 4, 0);
      7'd47:  r = ui(U_LDC, 5, 0, 0, 5, 0);
      7'd48:  r = ui(U_LDC, 6, 0, 0, 6, 0);
      7'd49:  r = ui(U_LDC, 7, 0, 0, 7, 0);
      7'd50:  r = ui(U_LDC, 8, 0, 0, 8, 0);
      7'd51:  r = ui(U_LDC, 16, 0, 0, 12, 0);
      7'd52:  r = ui(U_LDC, 17, 0, 0, 13, 0);
      7'd53:  r = ui(U_SETB, 0, 3, 0, 0, 0);
      7'd54:  r = ui(U_SETB, 0, 4, 0, 0, 1);
      7'd55:  r = ui(U_JMP, 0, 0, 0, 0, 0);
      7'd56:  r = ui(U_LDC, 0, 0, 0, 0, 0);
      7'd57:  r = ui(U_LDC, 1, 0, 0, 1, 0);
      7'd58:  r = ui(U_LDC, 2, 0, 0, 2, 0);
      7'd59:  r = ui(U_LDC, 3, 0, 0, 3, 0);
      7'd60:  r = ui(U_LDC, 4, 0, 0, 4, 0);
      7'd61:  r = ui(U_LDC, 5, 0, 0, 5, 0);
      7'd62:  r = ui(U_LDC, 6, 0, 0, 6, 0);
      7'd63:  r = ui(U_LDC, 7, 0, 0, 7, 0);
      7'd64:  r = ui(U_LDC, 8, 0, 0, 8, 0);
      7'd65:  r = ui(U_LDC, 9, 0, 0, 9, 0);
      7'd66:  r = ui(U_LDC, 10, 0, 0, 10, 0);
      7'd67:  r = ui(U_LDC, 11, 0, 0, 11, 0);
      7'd68:  r = ui(U_LDC, 12, 0, 0, 12, 0);
      7'd69:  r = ui(U_LDC, 13, 0, 0, 13, 0);
      7'd70:  r = ui(U_SETB, 0, 3, 0, 0, 0);
      7'd71:  r = ui(U_SETB, 0, 4, 0, 0, 1);
      7'd72:  r = ui(U_NEG, 14, 1, 0, 0, 0);
      7'd73:  r = ui(U_LDB, 18, 0, 0, 2, 0);
      7'd74:  r = ui(U_LDB, 19, 0, 0, 0, 0);
      7'd75:  r = ui(U_LDB, 20, 0, 0, 1, 0);
      7'd76:  r = ui(U_MUL, 21, 18, 6, 0, 0);
      7'd77:  r = ui(U_NEG, 21, 21, 0, 0, 0);
      7'd78:  r = ui(U_ADD, 19, 19, 21, 0, 0);
      7'd79:  r = ui(U_MUL, 21, 18, 5, 0, 0);
      7'd80:  r = ui(U_ADD, 20, 20, 21, 0, 0);
      7'd81:  r = ui(U_LDB, 18, 0, 0, 2, 1);
      7'd82:  r = ui(U_LDB, 22, 0, 0, 0, 1);
      7'd83:  r = ui(U_LDB, 23, 0, 0, 1, 1);
      7'd84:  r = ui(U_MUL, 21, 18, 8, 0, 0);
      7'd85:  r = ui(U_NEG, 21, 21, 0, 0, 0);
      7'd86:  r = ui(U_ADD, 22, 22, 21, 0, 0);
      7'd87:  r = ui(U_MUL, 21, 18, 7, 0, 0);
      7'd88:  r = ui(U_ADD, 23, 23, 21, 0, 0);
      7'd89:  r = ui(U_SUB, 24, 22, 19, 0, 0);
      7'd90:  r = ui(U_SUB, 25, 23, 20, 0, 0);
      7'd91:  r = ui(U_MUL, 21, 24, 0, 0, 0);
      7'd92:  r = ui(U_MUL, 26, 25, 1, 0, 0);
      7'd93:  r = ui(U_ADD, 26, 21, 26, 0, 0);
      7'd94:  r = ui(U_SUB, 21, 11, 26, 0, 0);
      7'd95:  r = ui(U_MUL, 21, 21, 9, 0, 0);
      7'd96:  r = ui(U_ADD, 27, 12, 21, 0, 0);
      7'd97:  r = ui(U_MAX0, 27, 27, 0, 0, 0);
      7'd98:  r = ui(U_SUB, 16, 27, 12, 0, 0);
      7'd99:  r = ui(U_MUL, 21, 24, 14, 0, 0);
      7'd100: r = ui(U_MUL, 26, 25, 0, 0, 0);
      7'd101: r = ui(U_ADD, 26, 21, 26, 0, 0);
      7'd102: r = ui(U_NEG, 26, 26, 0, 0, 0);
      7'd103: r = ui(U_MUL, 26, 26, 10, 0, 0);
      7'd104: r = ui(U_MUL, 28, 2, 27, 0, 0);
      7'd105: r = ui(U_MAX0, 28, 28, 0, 0, 0);
      7'd106: r = ui(U_ADD, 29, 13, 26, 0, 0);
      7'd107: r = ui(U_CLAMP, 29, 29, 28, 0, 0);
      7'd108: r = ui(U_SUB, 17, 29, 13, 0, 0);
      7'd109: r = ui(U_STC, 0, 27, 0, 12, 0);
      7'd110: r = ui(U_STC, 0, 29, 0, 13, 0);
      7'd111: r = ui(U_JMP, 0, 0, 0, 0, 0);
      7'd112: r = ui(U_XFER, 0, 0, 0, 0, 0);
      default: r = ui(U_END, 0, 0, 0, 0, 0);
    endcase
    return r;
  endfunction

endpackage

/* src/cis_ctrl.sv */
module cis_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic [2:0]    operation,
  input  logic [5:0]    contact_slot,
  input  logic          rsp_stall,
  output logic          busy,
  output logic          done,
  output cis_pkg::cmd_t cmd
);
  import cis_pkg::*;

  state_t          state, state_next;
  logic [PC_W-1:0] pc, entry;
  logic            cok;
  uinst_t          cur;

  assign cok = int'(contact_slot) < NUM_CONTACTS;
  assign cur = ucode(pc);

  always_comb begin
    case (operation)
      OP_WR_C, OP_WR_B, OP_RD_C, OP_RD_B: entry = PC_W'(WORD_PC);
      OP_WARM:  entry = cok ? PC_W'(WARM_PC) : PC_W'(END_PC);
      OP_SOLVE: entry = cok ? PC_W'(SOLVE_PC) : PC_W'(END_PC);
      default:  entry = PC_W'(END_PC);
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (req_valid) state_next = S_ISSUE;
      S_ISSUE:  state_next = S_COMMIT;
      S_COMMIT: state_next = (cur.op == U_END) ? S_RESP : S_ISSUE;
      S_RESP:   if (!rsp_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.accept = (state == S_IDLE) && req_valid;
    cmd.issue  = (state == S_ISSUE);
    cmd.commit = (state == S_COMMIT);
    cmd.ui     = cur;
    busy       = (state != S_IDLE);
    done       = (state == S_RESP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && req_valid) pc <= entry;
      else if (state == S_COMMIT) begin
        if (cur.op == U_JMP) pc <= PC_W'(APPLY_PC);
        else if (cur.op != U_END) pc <= pc + 1'b1;
      end
    end
  end

endmodule

/* src/cis_dpath.sv */
module cis_dpath (
  input  logic          clk,
  input  cis_pkg::cmd_t cmd,
  input  cis_pkg::in_t  req,
  output cis_pkg::out_t rsp
);
  import cis_pkg::*;

  logic [31:0]       cmem [CDEPTH];
  logic [31:0]       bmem [BDEPTH];
  logic [31:0]       rf [32];
  logic [BI_W-1:0]   breg [2];
  in_t               item;
  logic [31:0]       c_q, b_q, ra_q, rb_q, alu, rf_wd, mn, nb;
  logic [CA_W-1:0]   caddr;
  logic [BA_W-1:0]   baddr;
  logic [3:0]        kw;
  logic [BI_W-1:0]   bsel;
  logic signed [63:0] prod, a64, b64;
  logic              xfer, c_we, b_we, rf_we, cok, bok, cw_ok, bw_ok;

  assign xfer  = (cmd.ui.op == U_XFER);
  assign kw    = xfer ? item.word_select : cmd.ui.k;
  assign bsel  = xfer ? BI_W'(item.body_index) : breg[cmd.ui.bs];
  assign caddr = CA_W'(int'(item.contact_slot) * CWORDS + int'(kw));
  assign baddr = BA_W'(int'(bsel) * BWORDS + int'(kw));
  assign cok   = int'(item.contact_slot) < NUM_CONTACTS;
  assign bok   = (item.body_index != '0) && (int'(item.body_index) < NUM_BODIES);
  assign cw_ok = int'(item.word_select) < CWORDS;
  assign bw_ok = int'(item.word_select) < BWORDS;

  assign c_we = cmd.commit && ((cmd.ui.op == U_STC) ||
                (xfer && item.operation == OP_WR_C && cw_ok && cok));
  assign b_we = cmd.commit && (((cmd.ui.op == U_STB) && bsel != '0) ||
                (xfer && item.operation == OP_WR_B && bw_ok && bok));

  always_comb begin
    a64  = {{32{ra_q[31]}}, ra_q};
    b64  = {{32{rb_q[31]}}, rb_q};
    prod = a64 * b64;
    mn   = ($signed(ra_q) > $signed(rb_q)) ? rb_q : ra_q;
    nb   = sat64(-b64);
    case (cmd.ui.op)
      U_MUL:   alu = sat64(prod >>> FRAC_BITS);
      U_ADD:   alu = sat64(a64 + b64);
      U_SUB:   alu = sat64(a64 - b64);
      U_NEG:   alu = sat64(-a64);
      U_MAX0:  alu = ra_q[31] ? '0 : ra_q;
      U_CLAMP: alu = ($signed(mn) < $signed(nb)) ? nb : mn;
      default: alu = '0;
    endcase
    case (cmd.ui.op)
      U_LDC:   rf_wd = c_q;
      U_LDB:   rf_wd = (bsel == '0) ? '0 : b_q;
      default: rf_wd = alu;
    endcase
    case (cmd.ui.op)
      U_LDC, U_LDB, U_MUL, U_ADD, U_SUB, U_NEG, U_MAX0, U_CLAMP: rf_we = cmd.commit;
      default: rf_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (c_we) cmem[caddr] <= xfer ? item.write_value : ra_q;
    if (cmd.issue) c_q <= cmem[caddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) bmem[baddr] <= xfer ? item.write_value : ra_q;
    if (cmd.issue) b_q <= bmem[baddr];
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf[cmd.ui.d] <= rf_wd;
    if (cmd.issue) begin
      ra_q <= rf[cmd.ui.a];
      rb_q <= rf[cmd.ui.b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && cmd.ui.op == U_SETB) begin
      breg[cmd.ui.bs] <= (!ra_q[31] && ra_q != '0 && $signed(ra_q) < NUM_BODIES) ?
                         BI_W'(ra_q) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item           <= req;
      rsp.read_value <= '0;
      case (req.operation)
        OP_WR_C, OP_RD_C: rsp.status <= !(int'(req.word_select) < CWORDS);
        OP_WR_B, OP_RD_B: rsp.status <= !(int'(req.word_select) < BWORDS);
        default:          rsp.status <= 1'b0;
      endcase
    end else if (cmd.commit && xfer) begin
      if (item.operation == OP_RD_C && cw_ok && cok) rsp.read_value <= c_q;
      if (item.operation == OP_RD_B && bw_ok && bok) rsp.read_value <= b_q;
    end
  end

endmodule

/* src/contact_impulse_solver_2d_unit.sv */
// 2D sequential-impulse contact solver, signed Q16.16.
// req channel: one transfer carries operation, contact_slot, body_index,
// word_select and write_value. rsp channel: one transfer per item with
// read_value (zero unless a word read) and status (1 on a bad word_select).
// A microcoded sequencer runs each item through one shared datapath; every
// micro-step has an issue state (register/memory read), then a commit state
// (execute and write). One item is in flight at a time: req_stall stays high
// after the transfer until the response transfers, so no new item is taken
// before the last response has transferred. While rsp_stall is high the
// response holds and no new item is taken.
// Reset returns the sequencer to idle; store contents are undefined until
// written, and body index zero always reads as zero.
module contact_impulse_solver_2d_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cis_pkg::in_t  req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output cis_pkg::out_t rsp
);
  import cis_pkg::*;

  cmd_t cmd;

  cis_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .operation    (req.operation),
    .contact_slot (req.contact_slot),
    .rsp_stall    (rsp_stall),
    .busy         (req_stall),
    .done         (rsp_valid),
    .cmd          (cmd)
  );

  cis_dpath u_dpath (
    .clk (clk),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

`ifndef SYNTHESIS
  a_rsp_blocks_req: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall) else $error("request taken while response pending");
  a_req_no_rsp: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> !rsp_valid) else $error("response without work");
  a_rsp_frees: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall) |=> !req_stall) else $error("not idle after response");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import cis_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int CW_NX = 0, CW_NY = 1, CW_FRIC = 2, CW_BODY1 = 3, CW_BODY2 = 4;
  localparam int CW_NMASS = 9, CW_TMASS = 10, CW_BIAS = 11, CW_ACCN = 12, CW_ACCT = 13;
  localparam int BW_VX = 0, BW_VY = 1, BW_W = 2, BW_IMASS = 3, BW_IINERT = 4;
  localparam int LIVE_BODIES = 16;
  localparam int LIVE_SLOTS = 16;
  localparam int CYCLE_LIMIT = 2000000;

  class solver_scoreboard;
    int contact_mem[CDEPTH];
    int body_mem[BDEPTH];
    out_t pending[$];
    int errors;

    function int sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function int qadd(int a, int b); return sat(longint'(a) + longint'(b)); endfunction
    function int qsub(int a, int b); return sat(longint'(a) - longint'(b)); endfunction
    function int qneg(int a); return sat(-longint'(a)); endfunction
    function int qmul(int a, int b); return sat((longint'(a) * longint'(b)) >>> FRAC_BITS);
    endfunction

    function int body_of(int w);
      return (w >= 1 && w < NUM_BODIES) ? w : 0;
    endfunction

    function int bword(int b, int w);
      return (b == 0) ? 0 : body_mem[b * BWORDS + w];
    endfunction

    function void push_body(int b, int rx, int ry, int px, int py, bit add);
      int dx, dy, dw, base;
      if (b == 0) return;
      base = b * BWORDS;
      dx = qmul(px, body_mem[base + BW_IMASS]);
      dy = qmul(py, body_mem[base + BW_IMASS]);
      dw = qmul(qsub(qmul(rx, py), qmul(ry, px)), body_mem[base + BW_IINERT]);
      if (add) begin
        body_mem[base + BW_VX] = qadd(body_mem[base + BW_VX], dx);
        body_mem[base + BW_VY] = qadd(body_mem[base + BW_VY], dy);
        body_mem[base + BW_W]  = qadd(body_mem[base + BW_W], dw);
      end else begin
        body_mem[base + BW_VX] = qsub(body_mem[base + BW_VX], dx);
        body_mem[base + BW_VY] = qsub(body_mem[base + BW_VY], dy);
        body_mem[base + BW_W]  = qsub(body_mem[base + BW_W], dw);
      end
    endfunction

    function void apply_impulse(int cb, int jn, int jt);
      int nx, ny, px, py;
      nx = contact_mem[cb + CW_NX];
      ny = contact_mem[cb + CW_NY];
      px = qadd(qmul(nx, jn), qmul(qneg(ny), jt));
      py = qadd(qmul(ny, jn), qmul(nx, jt));
      push_body(body_of(contact_mem[cb + CW_BODY1]), contact_mem[cb + 5],
                contact_mem[cb + 6], px, py, 1'b0);
      push_body(body_of(contact_mem[cb + CW_BODY2]), contact_mem[cb + 7],
                contact_mem[cb + 8], px, py, 1'b1);
    endfunction

    function void solve_contact(int cb);
      int b1, b2, nx, ny, w1, w2, a1x, a1y, a2x, a2y, dvx, dvy, vn, jn;
      int oldn, newn, vt, jt, lim, oldt, newt;
      b1 = body_of(contact_mem[cb + CW_BODY1]);
      b2 = body_of(contact_mem[cb + CW_BODY2]);
      nx = contact_mem[cb + CW_NX];
      ny = contact_mem[cb + CW_NY];
      w1 = bword(b1, BW_W);
      w2 = bword(b2, BW_W);
      a1x = qadd(bword(b1, BW_VX), qneg(qmul(w1, contact_mem[cb + 6])));
      a1y = qadd(bword(b1, BW_VY), qmul(w1, contact_mem[cb + 5]));
      a2x = qadd(bword(b2, BW_VX), qneg(qmul(w2, contact_mem[cb + 8])));
      a2y = qadd(bword(b2, BW_VY), qmul(w2, contact_mem[cb + 7]));
      dvx = qsub(a2x, a1x);
      dvy = qsub(a2y, a1y);
      vn = qadd(qmul(dvx, nx), qmul(dvy, ny));
      jn = qmul(qsub(contact_mem[cb + CW_BIAS], vn), contact_mem[cb + CW_NMASS]);
      oldn = contact_mem[cb + CW_ACCN];
      newn = qadd(oldn, jn);
      if (newn < 0) newn = 0;
      vt = qadd(qmul(dvx, qneg(ny)), qmul(dvy, nx));
      jt = qmul(qneg(vt), contact_mem[cb + CW_TMASS]);
      lim = qmul(contact_mem[cb + CW_FRIC], newn);
      if (lim < 0) lim = 0;
      oldt = contact_mem[cb + CW_ACCT];
      newt = qadd(oldt, jt);
      if (newt > lim) newt = lim;
      if (newt < -lim) newt = -lim;
      contact_mem[cb + CW_ACCN] = newn;
      contact_mem[cb + CW_ACCT] = newt;
      apply_impulse(cb, qsub(newn, oldn), qsub(newt, oldt));
    endfunction

    function void note_transfer(in_t x);
      out_t r;
      int cb, bb;
      bit bok;
      r = '0;
      cb = int'(x.contact_slot) * CWORDS;
      bb = int'(x.body_index) * BWORDS;
      bok = x.body_index != 0;
      case (x.operation)
        OP_WR_C: if (x.word_select >= CWORDS) r.status = 1'b1;
                 else contact_mem[cb + x.word_select] = x.write_value;
        OP_WR_B: if (x.word_select >= BWORDS) r.status = 1'b1;
                 else if (bok) body_mem[bb + x.word_select] = x.write_value;
        OP_RD_C: if (x.word_select >= CWORDS) r.status = 1'b1;
                 else r.read_value = contact_mem[cb + x.word_select];
        OP_RD_B: if (x.word_select >= BWORDS) r.status = 1'b1;
                 else if (bok) r.read_value = body_mem[bb + x.word_select];
        OP_WARM: apply_impulse(cb, contact_mem[cb + CW_ACCN], contact_mem[cb + CW_ACCT]);
        OP_SOLVE: solve_contact(cb);
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected transfer read_value=%h status=%0d", $time,
                 got.read_value, got.status);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.read_value !== exp_r.read_value) begin
        $display("%0t: read_value expected %h actual %h", $time, exp_r.read_value,
                 got.read_value);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_stall = 1'b0;
  logic req_stall, rsp_valid;
  in_t req = '0;
  out_t rsp;

  solver_scoreboard sb = new();
  bit cw_done[CDEPTH];
  bit bw_done[BDEPTH];
  int burst_left = 0;
  int stall_mode = 0;
  int cycles = 0;

  contact_impulse_solver_2d_unit u_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp);
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= ($urandom_range(0, 9) < 7);
      default: rsp_stall <= ($urandom_range(0, 63) != 0);
    endcase
  end

  function in_t mk(logic [2:0] op, int slot, int body, int ws, int val);
    in_t x;
    x.operation = op;
    x.contact_slot = 6'(slot);
    x.body_index = 6'(body);
    x.word_select = 4'(ws);
    x.write_value = val;
    return x;
  endfunction

  function int small_q(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function int contact_val(int w);
    if ($urandom_range(0, 19) == 0) return $urandom;
    case (w)
      CW_NX, CW_NY: return small_q(65536);
      CW_FRIC: return ($urandom_range(0, 7) == 0) ? -small_q(65536) : $urandom_range(0, 65536);
      CW_BODY1, CW_BODY2: begin
        case ($urandom_range(0, 9))
          0: return 0;
          1: return $urandom;
          default: return $urandom_range(1, LIVE_BODIES - 1);
        endcase
      end
      CW_NMASS, CW_TMASS: return $urandom_range(0, 131072);
      default: return small_q(131072);
    endcase
  endfunction

  function int body_val(int w);
    if ($urandom_range(0, 19) == 0) return $urandom;
    if (w >= BW_IMASS) return $urandom_range(0, 131072);
    return small_q(262144);
  endfunction

  task automatic send(in_t x);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    req <= x;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_transfer(x);
    case (x.operation)
      OP_WR_C: if (x.word_select < CWORDS) cw_done[x.contact_slot * CWORDS + x.word_select] = 1;
      OP_WR_B: if (x.word_select < BWORDS) bw_done[x.body_index * BWORDS + x.word_select] = 1;
      default: ;
    endcase
  endtask

  task automatic send_random();
    int pick, slot, body, ws;
    pick = $urandom_range(0, 99);
    slot = $urandom_range(0, LIVE_SLOTS - 1);
    if (pick < 35) send(mk(OP_SOLVE, slot, $urandom, $urandom, $urandom));
    else if (pick < 45) send(mk(OP_WARM, slot, $urandom, $urandom, $urandom));
    else if (pick < 60) begin
      if ($urandom_range(0, 3) == 0) slot = $urandom_range(0, NUM_CONTACTS - 1);
      ws = $urandom_range(0, CWORDS - 1);
      send(mk(OP_WR_C, slot, $urandom, ws, contact_val(ws)));
    end else if (pick < 72) begin
      body = $urandom_range(0, 4) == 0 ? $urandom_range(0, NUM_BODIES - 1)
                                       : $urandom_range(1, LIVE_BODIES - 1);
      ws = $urandom_range(0, BWORDS - 1);
      send(mk(OP_WR_B, slot, body, ws, body_val(ws)));
    end else if (pick < 82) begin
      slot = $urandom_range(0, NUM_CONTACTS - 1);
      ws = $urandom_range(0, CWORDS - 1);
      if (!cw_done[slot * CWORDS + ws]) slot = $urandom_range(0, LIVE_SLOTS - 1);
      send(mk(OP_RD_C, slot, $urandom, ws, $urandom));
    end else if (pick < 92) begin
      body = $urandom_range(0, NUM_BODIES - 1);
      ws = $urandom_range(0, BWORDS - 1);
      if (body != 0 && !bw_done[body * BWORDS + ws]) body = $urandom_range(0, LIVE_BODIES - 1);
      send(mk(OP_RD_B, slot, body, ws, $urandom));
    end else if (pick < 96) begin
      send(mk(3'($urandom_range(OP_WR_C, OP_RD_B)), $urandom, $urandom,
              $urandom_range(CWORDS, 15), $urandom));
    end else begin
      send(mk($urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI, $urandom, $urandom,
              $urandom, $urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int b = 1; b < LIVE_BODIES; b++)
      for (int w = 0; w < BWORDS; w++) send(mk(OP_WR_B, 0, b, w, body_val(w)));
    for (int s = 0; s < LIVE_SLOTS; s++)
      for (int w = 0; w < CWORDS; w++) send(mk(OP_WR_C, s, 0, w, contact_val(w)));

    send(mk(OP_WR_C, 0, 0, CW_BODY1, 5));
    send(mk(OP_WR_C, 0, 0, CW_BODY2, 5));
    send(mk(OP_SOLVE, 0, 0, 0, 0));
    send(mk(OP_WARM, 0, 0, 0, 0));
    send(mk(OP_WR_C, 1, 0, CW_BODY1, 0));
    send(mk(OP_WR_C, 1, 0, CW_BODY2, 99));
    send(mk(OP_SOLVE, 1, 0, 0, 0));
    send(mk(OP_WR_C, 2, 0, CW_FRIC, -32768));
    send(mk(OP_SOLVE, 2, 0, 0, 0));
    send(mk(OP_WR_C, 63, 0, 13, 32'sh80000000));
    send(mk(OP_RD_C, 63, 0, 13, 0));
    send(mk(OP_WR_B, 0, 63, 4, 32'sh7fffffff));
    send(mk(OP_RD_B, 0, 63, 4, 0));
    send(mk(OP_WR_B, 0, 0, 0, 12345));
    send(mk(OP_RD_B, 0, 0, 0, 0));
    send(mk(OP_WR_C, 3, 0, 14, 1));
    send(mk(OP_RD_C, 3, 0, 15, 0));
    send(mk(OP_WR_B, 0, 1, 5, 1));
    send(mk(OP_RD_B, 0, 1, 15, 0));
    send(mk(OP_SPARE_LO, 0, 0, 0, 0));
    send(mk(OP_SPARE_HI, 63, 63, 15, -1));

    repeat (700) send_random();

    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
